// ===== rtl/slic_pkg.sv =====
// shared types and constants for the status led indicator controller
`default_nettype none

package slic_pkg;

  // event codes
  typedef enum logic [3:0] {
    CMD_TICK       = 4'd0,
    CMD_SET_STATE  = 4'd1,
    CMD_IDENTIFY   = 4'd2,
    CMD_HEARTBEAT  = 4'd3,
    CMD_DISCONNECT = 4'd4,
    CMD_ACTIVITY   = 4'd5,
    CMD_OVR_COLOUR = 4'd6,
    CMD_OVR_BLINK  = 4'd7,
    CMD_OVR_RESET  = 4'd8
  } cmd_t;

  // link state
  typedef enum logic [1:0] {
    LINK_WAITING   = 2'd0,
    LINK_SCANNED   = 2'd1,
    LINK_CONNECTED = 2'd2
  } link_t;

  // blink speed codes
  typedef enum logic [1:0] {
    SPD_NONE = 2'd0,
    SPD_SLOW = 2'd1,
    SPD_MID  = 2'd2,
    SPD_FAST = 2'd3
  } speed_t;

  // register indexes
  typedef enum logic [2:0] {
    REG_HB_TIMEOUT  = 3'd0,
    REG_ACT_TIMEOUT = 3'd1,
    REG_SLOW_HALF   = 3'd2,
    REG_MID_HALF    = 3'd3,
    REG_FAST_HALF   = 3'd4
  } reg_idx_t;

  localparam int unsigned AddrW    = 5;
  localparam int unsigned ElapsedW = 17;

  localparam logic [ElapsedW-1:0] ElapsedMax = {ElapsedW{1'b1}};

  localparam logic [15:0] HbTimeoutRst  = 16'd3000;
  localparam logic [15:0] ActTimeoutRst = 16'd500;
  localparam logic [15:0] SlowHalfRst   = 16'd500;
  localparam logic [15:0] MidHalfRst    = 16'd250;
  localparam logic [15:0] FastHalfRst   = 16'd125;

  localparam logic [23:0] ColWaiting   = 24'h402000;
  localparam logic [23:0] ColScanned   = 24'h004000;
  localparam logic [23:0] ColConnected = 24'h000040;
  localparam logic [7:0]  WhiteKey     = 8'hFF;

endpackage

`default_nettype wire

// ===== rtl/status_led_indicator_controller_core.sv =====
// top level of the status led indicator controller
`default_nettype none

// Status LED controller core. Each accepted request (tick, state change, heartbeat, activity,
// override commands) updates the link, timeout, override and blink state and yields at most
// one red/green/blue result, only when the shown colour changes or nothing was sent since
// reset. A request is held in the input register and is worked out by one pass of
// logic into the result register, so one request is taken every cycle; it is held only while
// a finished result is stalled at the output. Timing registers are written over the APB-style
// port at byte address 4*index and read back there; pready is always high.
module status_led_indicator_controller_core (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // request channel
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [3:0]                in_command,
  input  wire logic [1:0]                in_target_state,
  input  wire logic [7:0]                in_override_red,
  input  wire logic [7:0]                in_override_green,
  input  wire logic [7:0]                in_override_blue,
  input  wire logic [7:0]                in_blink_speed,
  // result channel
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [7:0]                     out_red,
  output logic [7:0]                     out_green,
  output logic [7:0]                     out_blue,
  // configuration port
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [slic_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import slic_pkg::*;

  // configuration registers
  logic [15:0] hb_timeout_r, act_timeout_r, slow_half_r, mid_half_r, fast_half_r;
  logic [2:0]  cfg_idx;

  // input register
  logic        in_full_r;
  logic [3:0]  cmd_r;
  logic [1:0]  tgt_r;
  logic [7:0]  ovr_r_r, ovr_g_r, ovr_b_r, spd_r;

  // block state
  link_t                link_r, link_nxt;
  logic                 act_blink_r, act_blink_nxt;
  logic                 ovr_act_r, ovr_act_nxt;
  logic [23:0]          ovr_col_r, ovr_col_nxt;
  speed_t               ovr_spd_r, ovr_spd_nxt;
  logic [15:0]          half_r, half_nxt;
  logic                 blink_on_r, blink_on_nxt;
  logic [15:0]          cdown_r, cdown_nxt;
  logic [ElapsedW-1:0]  hb_el_r, hb_el_nxt;
  logic [ElapsedW-1:0]  act_el_r, act_el_nxt;
  logic [23:0]          shown_r;
  logic                 shown_valid_r;

  // result register
  logic        out_valid_r;
  logic [23:0] out_col_r;

  logic        advance;
  logic [23:0] want_col;
  logic [15:0] want_half;
  logic [15:0] cdown_dec;
  logic [23:0] show;
  logic        emit;

  assign cfg_idx = paddr[AddrW-1:2];
  assign pready  = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hb_timeout_r  <= HbTimeoutRst;
      act_timeout_r <= ActTimeoutRst;
      slow_half_r   <= SlowHalfRst;
      mid_half_r    <= MidHalfRst;
      fast_half_r   <= FastHalfRst;
    end else if (psel && penable && pwrite) begin
      case (cfg_idx)
        REG_HB_TIMEOUT:  hb_timeout_r  <= pwdata[15:0];
        REG_ACT_TIMEOUT: act_timeout_r <= pwdata[15:0];
        REG_SLOW_HALF:   slow_half_r   <= pwdata[15:0];
        REG_MID_HALF:    mid_half_r    <= pwdata[15:0];
        REG_FAST_HALF:   fast_half_r   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (cfg_idx)
      REG_HB_TIMEOUT:  prdata = {16'd0, hb_timeout_r};
      REG_ACT_TIMEOUT: prdata = {16'd0, act_timeout_r};
      REG_SLOW_HALF:   prdata = {16'd0, slow_half_r};
      REG_MID_HALF:    prdata = {16'd0, mid_half_r};
      REG_FAST_HALF:   prdata = {16'd0, fast_half_r};
      default:         prdata = 32'd0;
    endcase
  end

  // the held request moves on once the result slot is free
  assign advance  = in_full_r && !(out_valid_r && out_stall);
  assign in_stall = in_full_r && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full_r <= 1'b1;
    end else if (advance) begin
      in_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd_r   <= in_command;
      tgt_r   <= in_target_state;
      ovr_r_r <= in_override_red;
      ovr_g_r <= in_override_green;
      ovr_b_r <= in_override_blue;
      spd_r   <= in_blink_speed;
    end
  end

  // command effects on link, override and timeout state
  always_comb begin
    link_nxt      = link_r;
    act_blink_nxt = act_blink_r;
    ovr_act_nxt   = ovr_act_r;
    ovr_col_nxt   = ovr_col_r;
    ovr_spd_nxt   = ovr_spd_r;
    hb_el_nxt     = hb_el_r;
    act_el_nxt    = act_el_r;
    case (cmd_r)
      CMD_TICK: begin
        if (hb_el_r != ElapsedMax) hb_el_nxt = hb_el_r + 1'b1;
        if (act_el_r != ElapsedMax) act_el_nxt = act_el_r + 1'b1;
        if (link_r == LINK_CONNECTED && hb_el_nxt > {1'b0, hb_timeout_r}) begin
          link_nxt      = LINK_WAITING;
          act_blink_nxt = 1'b0;
          ovr_act_nxt   = 1'b0;
          ovr_spd_nxt   = SPD_NONE;
        end
        if (act_blink_nxt && act_el_nxt > {1'b0, act_timeout_r}) act_blink_nxt = 1'b0;
      end
      CMD_SET_STATE: begin
        case (tgt_r)
          LINK_WAITING, LINK_SCANNED: begin
            link_nxt      = link_t'(tgt_r);
            act_blink_nxt = 1'b0;
          end
          LINK_CONNECTED: link_nxt = LINK_CONNECTED;
          default: ;
        endcase
      end
      CMD_IDENTIFY: begin
        link_nxt      = LINK_SCANNED;
        act_blink_nxt = 1'b0;
      end
      CMD_HEARTBEAT: begin
        hb_el_nxt = '0;
        link_nxt  = LINK_CONNECTED;
      end
      CMD_DISCONNECT: begin
        ovr_act_nxt   = 1'b0;
        ovr_spd_nxt   = SPD_NONE;
        act_blink_nxt = 1'b0;
        link_nxt      = LINK_SCANNED;
      end
      CMD_ACTIVITY: begin
        if (link_r == LINK_CONNECTED && !ovr_act_r) begin
          act_el_nxt    = '0;
          act_blink_nxt = 1'b1;
        end
      end
      CMD_OVR_COLOUR: begin
        // all-white colour cancels the override
        if (ovr_r_r == WhiteKey && ovr_g_r == WhiteKey && ovr_b_r == WhiteKey) begin
          ovr_act_nxt = 1'b0;
          ovr_spd_nxt = SPD_NONE;
        end else begin
          ovr_act_nxt = 1'b1;
          ovr_col_nxt = {ovr_r_r, ovr_g_r, ovr_b_r};
        end
      end
      CMD_OVR_BLINK: ovr_spd_nxt = (spd_r > 8'd3) ? SPD_NONE : speed_t'(spd_r[1:0]);
      CMD_OVR_RESET: begin
        ovr_act_nxt = 1'b0;
        ovr_spd_nxt = SPD_NONE;
      end
      default: ;
    endcase
  end

  // wanted colour and half period from the updated state
  always_comb begin
    if (ovr_act_nxt) begin
      want_col = ovr_col_nxt;
      case (ovr_spd_nxt)
        SPD_SLOW: want_half = slow_half_r;
        SPD_MID:  want_half = mid_half_r;
        SPD_FAST: want_half = fast_half_r;
        default:  want_half = 16'd0;
      endcase
    end else begin
      case (link_nxt)
        LINK_WAITING: begin
          want_col  = ColWaiting;
          want_half = 16'd0;
        end
        LINK_SCANNED: begin
          want_col  = ColScanned;
          want_half = 16'd0;
        end
        default: begin
          want_col  = ColConnected;
          want_half = act_blink_nxt ? fast_half_r : 16'd0;
        end
      endcase
    end
  end

  // blink phase: take over a new half period, else count down on ticks
  assign cdown_dec = (cdown_r != 16'd0) ? cdown_r - 16'd1 : 16'd0;

  always_comb begin
    half_nxt     = half_r;
    blink_on_nxt = blink_on_r;
    cdown_nxt    = cdown_r;
    if (want_half != half_r) begin
      half_nxt     = want_half;
      blink_on_nxt = 1'b1;
      cdown_nxt    = want_half;
    end else if (cmd_r == CMD_TICK && half_r != 16'd0) begin
      if (cdown_dec == 16'd0) begin
        cdown_nxt    = half_r;
        blink_on_nxt = !blink_on_r;
      end else begin
        cdown_nxt = cdown_dec;
      end
    end
  end

  // colour on the led and whether it is new
  assign show = (half_nxt == 16'd0 || blink_on_nxt) ? want_col : 24'd0;
  assign emit = !shown_valid_r || (show != shown_r);

  // state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r        <= LINK_WAITING;
      act_blink_r   <= 1'b0;
      ovr_act_r     <= 1'b0;
      ovr_col_r     <= 24'd0;
      ovr_spd_r     <= SPD_NONE;
      half_r        <= 16'd0;
      blink_on_r    <= 1'b1;
      cdown_r       <= 16'd0;
      hb_el_r       <= '0;
      act_el_r      <= '0;
      shown_r       <= 24'd0;
      shown_valid_r <= 1'b0;
    end else if (advance) begin
      link_r      <= link_nxt;
      act_blink_r <= act_blink_nxt;
      ovr_act_r   <= ovr_act_nxt;
      ovr_col_r   <= ovr_col_nxt;
      ovr_spd_r   <= ovr_spd_nxt;
      half_r      <= half_nxt;
      blink_on_r  <= blink_on_nxt;
      cdown_r     <= cdown_nxt;
      hb_el_r     <= hb_el_nxt;
      act_el_r    <= act_el_nxt;
      if (emit) begin
        shown_r       <= show;
        shown_valid_r <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) out_col_r <= show;
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_col_r[23:16];
  assign out_green = out_col_r[15:8];
  assign out_blue  = out_col_r[7:0];

endmodule

`default_nettype wire

// ===== tb/led_colour_checker.sv =====
`timescale 1ns / 1ps
// checker that predicts the status led colour results and compares them with the block's output

module led_colour_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [3:0]                 in_command,
  input  logic [1:0]                 in_target_state,
  input  logic [7:0]                 in_override_red,
  input  logic [7:0]                 in_override_green,
  input  logic [7:0]                 in_override_blue,
  input  logic [7:0]                 in_blink_speed,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [7:0]                 out_red,
  input  logic [7:0]                 out_green,
  input  logic [7:0]                 out_blue,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [slic_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  input  logic                       pready,
  output int unsigned                fail_count,
  output int unsigned                colours_pending,
  output int unsigned                requests_seen,
  output int unsigned                colours_seen
);
  import slic_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } led_colour_t;

  // timing registers as last written
  logic [15:0] hb_timeout, act_timeout, slow_half, mid_half, fast_half;

  // predicted controller state
  link_t         link;
  bit            act_blink;
  bit            ovr_on;
  logic [23:0]   ovr_colour;
  speed_t        ovr_speed;
  logic [15:0]   half_now;
  bit            phase_on;
  logic [15:0]   toggle_cnt;
  logic [16:0]   hb_elapsed;
  logic [16:0]   act_elapsed;
  logic [23:0]   last_colour;
  bit            last_valid;

  // colours the block still owes, oldest first
  led_colour_t   colours_due[$];

  task automatic set_link(input link_t s);
    link = s;
    if (s != LINK_CONNECTED) act_blink = 1'b0;
  endtask

  task automatic clear_override();
    ovr_on = 1'b0;
    ovr_speed = SPD_NONE;
  endtask

  // pick the wanted colour and take over a changed blink half period
  task automatic retune_blink(output logic [23:0] colour, output bit retuned);
    logic [15:0] half;
    if (ovr_on) begin
      colour = ovr_colour;
      case (ovr_speed)
        SPD_SLOW: half = slow_half;
        SPD_MID:  half = mid_half;
        SPD_FAST: half = fast_half;
        default:  half = 16'd0;
      endcase
    end else if (link == LINK_WAITING) begin
      colour = ColWaiting;
      half = 16'd0;
    end else if (link == LINK_SCANNED) begin
      colour = ColScanned;
      half = 16'd0;
    end else begin
      colour = ColConnected;
      half = act_blink ? fast_half : 16'd0;
    end
    retuned = (half != half_now);
    if (retuned) begin
      half_now = half;
      phase_on = 1'b1;
      toggle_cnt = half;
    end
  endtask

  // apply one request and decide whether a new colour goes out
  task automatic advance_led(input logic [3:0] cmd, input logic [1:0] target,
                             input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue, input logic [7:0] speed,
                             output bit emit, output logic [23:0] shown);
    logic [23:0] colour;
    bit          retuned;
    case (cmd)
      CMD_TICK: begin
        if (hb_elapsed != ElapsedMax) hb_elapsed = hb_elapsed + 1'b1;
        if (act_elapsed != ElapsedMax) act_elapsed = act_elapsed + 1'b1;
        if (link == LINK_CONNECTED && hb_elapsed > {1'b0, hb_timeout}) begin
          link = LINK_WAITING;
          act_blink = 1'b0;
          clear_override();
        end
        if (act_blink && act_elapsed > {1'b0, act_timeout}) act_blink = 1'b0;
        retune_blink(colour, retuned);
        if (!retuned && half_now != 16'd0) begin
          if (toggle_cnt != 16'd0) toggle_cnt = toggle_cnt - 1'b1;
          if (toggle_cnt == 16'd0) begin
            toggle_cnt = half_now;
            phase_on = !phase_on;
          end
        end
      end
      CMD_SET_STATE: begin
        if (target <= LINK_CONNECTED) set_link(link_t'(target));
      end
      CMD_IDENTIFY: set_link(LINK_SCANNED);
      CMD_HEARTBEAT: begin
        hb_elapsed = '0;
        if (link != LINK_CONNECTED) set_link(LINK_CONNECTED);
      end
      CMD_DISCONNECT: begin
        clear_override();
        act_blink = 1'b0;
        set_link(LINK_SCANNED);
      end
      CMD_ACTIVITY: begin
        if (link == LINK_CONNECTED && !ovr_on) begin
          act_elapsed = '0;
          act_blink = 1'b1;
        end
      end
      CMD_OVR_COLOUR: begin
        // all-white acts as an override reset
        if (red == WhiteKey && green == WhiteKey && blue == WhiteKey) begin
          clear_override();
        end else begin
          ovr_on = 1'b1;
          ovr_colour = {red, green, blue};
        end
      end
      CMD_OVR_BLINK: ovr_speed = (speed > 8'd3) ? SPD_NONE : speed_t'(speed[1:0]);
      CMD_OVR_RESET: clear_override();
      default: ;
    endcase
    retune_blink(colour, retuned);
    shown = (half_now == 16'd0 || phase_on) ? colour : 24'h0;
    emit = !(last_valid && shown == last_colour);
    if (emit) begin
      last_colour = shown;
      last_valid = 1'b1;
    end
  endtask

  always @(posedge clk) begin : watch
    led_colour_t due;
    logic [23:0] shown;
    bit          emit;
    if (!rst_n) begin
      hb_timeout = HbTimeoutRst;
      act_timeout = ActTimeoutRst;
      slow_half = SlowHalfRst;
      mid_half = MidHalfRst;
      fast_half = FastHalfRst;
      link = LINK_WAITING;
      act_blink = 1'b0;
      ovr_on = 1'b0;
      ovr_colour = '0;
      ovr_speed = SPD_NONE;
      half_now = '0;
      phase_on = 1'b1;
      toggle_cnt = '0;
      hb_elapsed = '0;
      act_elapsed = '0;
      last_colour = '0;
      last_valid = 1'b0;
      colours_due.delete();
      fail_count = 0;
      requests_seen = 0;
      colours_seen = 0;
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[AddrW-1:2])
          REG_HB_TIMEOUT:  hb_timeout = pwdata[15:0];
          REG_ACT_TIMEOUT: act_timeout = pwdata[15:0];
          REG_SLOW_HALF:   slow_half = pwdata[15:0];
          REG_MID_HALF:    mid_half = pwdata[15:0];
          REG_FAST_HALF:   fast_half = pwdata[15:0];
          default: ;
        endcase
      end
      // result request against the oldest expected colour
      if (out_valid && !out_stall) begin
        colours_seen++;
        if (colours_due.size() == 0) begin
          $error("unexpected colour %0d %0d %0d", out_red, out_green, out_blue);
          fail_count++;
        end else begin
          due = colours_due.pop_front();
          if (out_red !== due.red) begin
            $error("red: expected %0d, got %0d", due.red, out_red);
            fail_count++;
          end
          if (out_green !== due.green) begin
            $error("green: expected %0d, got %0d", due.green, out_green);
            fail_count++;
          end
          if (out_blue !== due.blue) begin
            $error("blue: expected %0d, got %0d", due.blue, out_blue);
            fail_count++;
          end
        end
      end
      // input request
      if (in_valid && !in_stall) begin
        requests_seen++;
        advance_led(in_command, in_target_state, in_override_red, in_override_green,
                    in_override_blue, in_blink_speed, emit, shown);
        if (emit) begin
          due = shown;
          colours_due.push_back(due);
        end
      end
    end
    colours_pending = colours_due.size();
  end

endmodule

// ===== tb/status_led_indicator_controller_core_tb.sv =====
`timescale 1ns / 1ps
// testbench top: drives events and register writes into the led controller and gives the verdict

module status_led_indicator_controller_core_tb;
  import slic_pkg::*;

  localparam int unsigned CycleLimit      = 2000000;
  localparam int unsigned SettleCycles    = 8;
  localparam logic [3:0]  CmdUnknownLo    = 4'd9;
  localparam logic [3:0]  CmdUnknownHi    = 4'd15;
  localparam logic [1:0]  TargetInvalid   = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [3:0]           in_command = '0;
  logic [1:0]           in_target_state = '0;
  logic [7:0]           in_override_red = '0;
  logic [7:0]           in_override_green = '0;
  logic [7:0]           in_override_blue = '0;
  logic [7:0]           in_blink_speed = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           out_red, out_green, out_blue;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [AddrW-1:0]     paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  int unsigned          fail_count, colours_pending, requests_seen, colours_seen;
  int unsigned          cycle_count = 0;
  int                   send_idle_pct = 0;
  int                   recv_idle_pct = 0;

  status_led_indicator_controller_core DUT (.*);

  led_colour_checker watcher (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stalls at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // one request, with a random idle gap in front
  task automatic send_request(input logic [3:0] cmd, input logic [1:0] target,
                              input logic [7:0] red, input logic [7:0] green,
                              input logic [7:0] blue, input logic [7:0] speed);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_target_state <= target;
    in_override_red <= red;
    in_override_green <= green;
    in_override_blue <= blue;
    in_blink_speed <= speed;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  // hold requests until every expected colour is out and the pipe is quiet
  task automatic drain_colours();
    in_valid <= 1'b0;
    @(negedge clk);
    while (colours_pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
    @(posedge clk);
  endtask

  // apb write: setup then access
  task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
    logic [15:0] upper;
    upper = 16'($urandom);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {upper, value};
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // one register setting and idle mix, then weighted random events
  task automatic run_phase(input int send_pct, input int recv_pct,
                           input logic [15:0] hb, input logic [15:0] act,
                           input logic [15:0] slow, input logic [15:0] mid,
                           input logic [15:0] fast, input int count);
    logic [31:0] roll;
    logic [31:0] spd_roll;
    logic [3:0]  cmd;
    logic [7:0]  red, green, blue, speed;
    int unsigned pick;
    drain_colours();
    write_reg(REG_HB_TIMEOUT, hb);
    write_reg(REG_ACT_TIMEOUT, act);
    write_reg(REG_SLOW_HALF, slow);
    write_reg(REG_MID_HALF, mid);
    write_reg(REG_FAST_HALF, fast);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      roll = $urandom;
      spd_roll = $urandom;
      if (pick < 40) cmd = CMD_TICK;
      else if (pick < 48) cmd = CMD_HEARTBEAT;
      else if (pick < 58) cmd = CMD_ACTIVITY;
      else if (pick < 64) cmd = CMD_SET_STATE;
      else if (pick < 67) cmd = CMD_IDENTIFY;
      else if (pick < 70) cmd = CMD_DISCONNECT;
      else if (pick < 78) cmd = CMD_OVR_COLOUR;
      else if (pick < 86) cmd = CMD_OVR_BLINK;
      else if (pick < 90) cmd = CMD_OVR_RESET;
      else if (pick < 93) cmd = 4'($urandom_range(CmdUnknownHi, CmdUnknownLo));
      else cmd = CMD_TICK;
      red = roll[7:0];
      green = roll[15:8];
      blue = roll[23:16];
      // now and then the all-white override reset
      if (roll[27:24] == 4'd0) begin
        red = WhiteKey;
        green = WhiteKey;
        blue = WhiteKey;
      end
      // mostly the legal speeds, sometimes any byte
      speed = (spd_roll[9:8] != 2'd0) ? {6'd0, spd_roll[1:0]} : spd_roll[31:24];
      send_request(cmd, roll[29:28], red, green, blue, speed);
      if (n == count / 2 || $urandom_range(99) == 0) drain_colours();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // short timings so the directed part reaches timeouts and toggles
    write_reg(REG_HB_TIMEOUT, 16'd4);
    write_reg(REG_ACT_TIMEOUT, 16'd3);
    write_reg(REG_SLOW_HALF, 16'd3);
    write_reg(REG_MID_HALF, 16'd2);
    write_reg(REG_FAST_HALF, 16'd1);
    send_idle_pct = 34;
    recv_idle_pct = 75;

    // directed corner cases
    send_request(CMD_TICK, LINK_WAITING, 8'h00, 8'h00, 8'h00, 8'd0);
    send_request(CmdUnknownLo, LINK_CONNECTED, 8'hFF, 8'hFF, 8'hFF, 8'd255);
    send_request(CmdUnknownHi, LINK_SCANNED, 8'h12, 8'h34, 8'h56, 8'd3);
    send_request(CMD_SET_STATE, TargetInvalid, 8'h00, 8'h00, 8'h00, 8'd0);
    send_request(CMD_SET_STATE, LINK_SCANNED, 8'h00, 8'h00, 8'h00, 8'd0);
    send_request(CMD_ACTIVITY, LINK_WAITING, 8'h00, 8'h00, 8'h00, 8'd0);
    send_request(CMD_HEARTBEAT, LINK_WAITING, 8'h00, 8'h00, 8'h00, 8'd0);
    send_request(CMD_ACTIVITY, LINK_WAITING, 8'h00, 8'h00, 8'h00, 8'd0);
    repeat (3) send_request(CMD_TICK, LINK_WAITING, 8'h00, 8'h00, 8'h00, 8'd0);
    send_request(CMD_OVR_COLOUR, LINK_WAITING, 8'h00, 8'h00, 8'h00, 8'd0);
    send_request(CMD_ACTIVITY, LINK_WAITING, 8'h00, 8'h00, 8'h00, 8'd0);
    send_request(CMD_OVR_BLINK, LINK_WAITING, 8'h00, 8'h00, 8'h00, 8'd200);
    send_request(CMD_OVR_BLINK, LINK_WAITING, 8'h00, 8'h00, 8'h00, {6'd0, SPD_FAST});
    repeat (2) send_request(CMD_TICK, LINK_WAITING, 8'h00, 8'h00, 8'h00, 8'd0);
    send_request(CMD_OVR_COLOUR, LINK_WAITING, 8'hFF, 8'hFF, 8'hFF, 8'd0);
    send_request(CMD_OVR_COLOUR, LINK_WAITING, 8'hFF, 8'hFF, 8'hFE, 8'd0);
    send_request(CMD_OVR_BLINK, LINK_WAITING, 8'h00, 8'h00, 8'h00, {6'd0, SPD_SLOW});
    send_request(CMD_OVR_RESET, LINK_WAITING, 8'h00, 8'h00, 8'h00, 8'd0);
    send_request(CMD_IDENTIFY, LINK_WAITING, 8'h00, 8'h00, 8'h00, 8'd0);
    send_request(CMD_DISCONNECT, LINK_WAITING, 8'h00, 8'h00, 8'h00, 8'd0);
    send_request(CMD_SET_STATE, LINK_CONNECTED, 8'h00, 8'h00, 8'h00, 8'd0);
    repeat (2) send_request(CMD_TICK, LINK_WAITING, 8'h00, 8'h00, 8'h00, 8'd0);

    // random events over several timing settings and idle mixes
    run_phase(34, 75, 16'd10, 16'd5, 16'd3, 16'd2, 16'd1, 175);
    run_phase(34, 75, 16'd0, 16'd0, 16'd1, 16'd1, 16'd1, 175);
    run_phase(75, 34, 16'd25, 16'd12, 16'd7, 16'd0, 16'd4, 175);
    run_phase(75, 34, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 175);
    run_phase(0, 0, 16'd6, 16'd4, 16'd2, 16'd3, 16'd0, 175);
    run_phase(0, 0, 16'd15, 16'd2, 16'd4, 16'd5, 16'd2, 175);

    // wait out the last colours
    in_valid <= 1'b0;
    @(negedge clk);
    while (colours_pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("covered %0d requests and %0d colour results: directed corners,",
             requests_seen, colours_seen);
    $display("then six timing settings under sender and receiver idle mixes");
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/slic_pkg.sv
rtl/status_led_indicator_controller_core.sv
tb/led_colour_checker.sv
tb/status_led_indicator_controller_core_tb.sv
